// ----- hdl/ecv_pkg.sv -----
// shared types and constants of the euler camera view matrix block
package ecv_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int BASIS_FRAC_BITS_DEF = 14;

  localparam logic [14:0] FOV_MIN_RESET = 15'd128;
  localparam logic [14:0] FOV_MAX_RESET = 15'd22912;

  localparam int CFG_AW = 3;
  localparam logic REG_FOV_MIN = 1'b0;
  localparam logic REG_FOV_MAX = 1'b1;

  localparam logic [1:0] COL_RIGHT = 2'd0;
  localparam logic [1:0] COL_UP    = 2'd1;
  localparam logic [1:0] COL_FWD   = 2'd2;
  localparam logic [1:0] COL_TRANS = 2'd3;

  localparam logic [16:0] W_ONE = 17'd65536;

  localparam logic [31:0] GAIN_Q30 = 32'd652032875;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [15:0]        yaw;
    logic [15:0]        pitch;
    logic [15:0]        roll;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [14:0]        fov;
  } ecv_item_t;

endpackage

// ----- hdl/ecv_in_if.sv -----
// pose input channel
interface ecv_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        yaw_angle;
  logic [15:0]        pitch_angle;
  logic [15:0]        roll_angle;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] fov_request;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, pos_x, pos_y, pos_z,
                  fov_request, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, pos_x, pos_y, pos_z,
                fov_request, output ready);
endinterface

// ----- hdl/ecv_out_if.sv -----
// matrix column result channel
interface ecv_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column_index;
  logic signed [39:0] elem_x;
  logic signed [39:0] elem_y;
  logic signed [39:0] elem_z;
  logic [16:0]        elem_w;
  logic [14:0]        fov_clamped;
  logic               last_column;

  modport source (output valid, column_index, elem_x, elem_y, elem_z, elem_w, fov_clamped,
                  last_column, input ready);
  modport sink (input valid, column_index, elem_x, elem_y, elem_z, elem_w, fov_clamped,
                last_column, output ready);
endinterface

// ----- hdl/euler_camera_view_matrix.sv -----
// Euler camera view matrix: takes one camera pose per transfer and returns the
// four view matrix columns (right, up, forward, translation) in that order,
// one column per output transfer, each carrying the clamped field of view.
// The pose is accepted into a two-entry queue and read out, whenever the
// pipeline advances, into three pipelined sine/cosine units (the read is
// their input register) and six further stages, the last of which holds the
// columns of a pose. The whole pipeline holds while the columns of a pose
// wait on the output. Poses are paced by the column serializer that sends
// the four results of a pose over the output channel; the pipeline takes the
// next pose as the last column of the current one is sent.
// Field of view limits are written over the APB port at byte addresses 0 and 4.
module euler_camera_view_matrix import ecv_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF,
  parameter int BASIS_FRAC_BITS = BASIS_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ecv_in_if.sink            in_ch,
  ecv_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [14:0] fov_min_r, fov_min_nxt, fov_max_r, fov_max_nxt;
  logic        wr;
  logic        q_valid, q_pop;
  ecv_item_t   q_item;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_comb begin
    fov_min_nxt = fov_min_r;
    fov_max_nxt = fov_max_r;
    if (wr) begin
      unique case (paddr[2])
        REG_FOV_MIN: fov_min_nxt = pwdata[14:0];
        REG_FOV_MAX: fov_max_nxt = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_min_r <= FOV_MIN_RESET;
      fov_max_r <= FOV_MAX_RESET;
    end else begin
      fov_min_r <= fov_min_nxt;
      fov_max_r <= fov_max_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FOV_MIN: prdata = {17'd0, fov_min_r};
      REG_FOV_MAX: prdata = {17'd0, fov_max_r};
      default:     prdata = '0;
    endcase
  end

  ecv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .fov_min(fov_min_r), .fov_max(fov_max_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

  ecv_back #(.ITER(TRIG_ITERATIONS), .BFB(BASIS_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_ch(out_ch));

endmodule

// ----- hdl/ecv_front.sv -----
// front end: pose intake, fov clamp and two-entry queue
module ecv_front import ecv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ecv_in_if.sink     in_ch,
  input  logic [14:0] fov_min,
  input  logic [14:0] fov_max,
  output logic       q_valid,
  output ecv_item_t  q_item,
  input  logic       q_pop
);

  ecv_item_t  mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  logic signed [16:0] f1, f2;
  ecv_item_t  item;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_pop && (cnt_r != 2'd0);

  always_comb begin
    f1 = 17'(in_ch.fov_request);
    if (f1 > signed'({2'b00, fov_max})) f1 = signed'({2'b00, fov_max});
    f2 = f1;
    if (f2 < signed'({2'b00, fov_min})) f2 = signed'({2'b00, fov_min});
    item.yaw   = in_ch.yaw_angle;
    item.pitch = in_ch.pitch_angle;
    item.roll  = in_ch.roll_angle;
    item.px    = in_ch.pos_x;
    item.py    = in_ch.pos_y;
    item.pz    = in_ch.pos_z;
    item.fov   = f2[14:0];
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

endmodule

// ----- hdl/ecv_cordic.sv -----
// pipelined sine and cosine of a 16-bit binary angle
module ecv_cordic import ecv_pkg::*; #(
  parameter int ITER = TRIG_ITERATIONS_DEF,
  parameter int BFB  = BASIS_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          angle,
  output logic signed [BFB+1:0] sin_o,
  output logic signed [BFB+1:0] cos_o
);

  localparam int XW   = 34;
  localparam int BW   = BFB + 2;
  localparam int DROP = 30 - BFB;
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (DROP - 1);
  localparam logic signed [XW-1:0] ONE  = XW'(1) <<< BFB;

  logic signed [XW-1:0] x_r [ITER+1];
  logic signed [XW-1:0] y_r [ITER+1];
  logic signed [XW-1:0] z_r [ITER+1];
  logic                 neg_r [ITER+1];
  logic [15:0]          sum, af;
  logic                 neg;

  function automatic logic signed [BW-1:0] fin(input logic signed [XW-1:0] v,
                                               input logic n);
    logic signed [XW-1:0] t;
    logic signed [BW-1:0] s;
    t = (v + HALF) >>> DROP;
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    s = t[BW-1:0];
    return n ? -s : s;
  endfunction

  always_comb begin
    sum = angle + 16'h4000;
    neg = sum[15];
    af  = neg ? (angle ^ 16'h8000) : angle;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= XW'(GAIN_Q30);
      y_r[0]   <= '0;
      z_r[0]   <= {{(XW-32){af[15]}}, af, 16'h0000};
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - signed'({2'b00, ATAN_TURNS[i]});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + signed'({2'b00, ATAN_TURNS[i]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= fin(x_r[ITER], neg_r[ITER]);
      sin_o <= fin(y_r[ITER], neg_r[ITER]);
    end
  end

endmodule

// ----- hdl/ecv_back.sv -----
// back end: basis, roll, translation and column serializer
module ecv_back import ecv_pkg::*; #(
  parameter int ITER = TRIG_ITERATIONS_DEF,
  parameter int BFB  = BASIS_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  ecv_item_t q_item,
  output logic      q_pop,
  ecv_out_if.source out_ch
);

  localparam int BW = BFB + 2;
  localparam int RW = BFB + 3;
  localparam int PW = 2 * BW + 1;
  localparam int DPW = RW + 32;
  localparam int DW = RW + 34;
  localparam int L  = ITER + 2;
  localparam int DN = (BFB > 16) ? BFB - 16 : 0;
  localparam int UP = (BFB < 16) ? 16 - BFB : 0;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (BFB - 1);
  localparam logic signed [DW-1:0] HALF_D = DW'(1) <<< (BFB - 1);
  localparam logic signed [39:0]   HALF_Q = (DN > 0) ? (40'sd1 <<< ((DN > 0) ? DN - 1 : 0))
                                                     : 40'sd0;
  localparam logic signed [DW-1:0] MAX40 = DW'(40'sh7FFFFFFFFF);
  localparam logic signed [DW-1:0] MIN40 = -MAX40 - DW'(1);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [14:0]        fov;
    logic               rnz;
  } side_t;

  function automatic logic signed [PW-1:0] ext2(input logic signed [2*BW-1:0] p);
    return PW'(p);
  endfunction

  function automatic logic signed [RW-1:0] rnd2(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] t;
    t = (s + HALF_P) >>> BFB;
    return t[RW-1:0];
  endfunction

  function automatic logic signed [39:0] q16(input logic signed [RW-1:0] v);
    logic signed [39:0] e;
    e = 40'(v);
    return (BFB > 16) ? ((e + HALF_Q) >>> DN) : (e <<< UP);
  endfunction

  function automatic logic signed [39:0] ndot(input logic signed [DPW-1:0] a,
                                              input logic signed [DPW-1:0] b,
                                              input logic signed [DPW-1:0] c);
    logic signed [DW-1:0] s, r;
    s = DW'(a) + DW'(b) + DW'(c);
    r = -((s + HALF_D) >>> BFB);
    if (r > MAX40) r = MAX40;
    if (r < MIN40) r = MIN40;
    return r[39:0];
  endfunction

  logic adv;
  logic signed [BW-1:0] sy, cy, sp, cp, sr, cr;

  side_t sd_r [L];
  logic  sd_v_r [L];

  logic  v1_r, v2_r, v3_r, v4_r, v5_r, fin_v_r;
  side_t s1_r, s2_r, s3_r, s4_r, s5_r;
  logic [1:0] col_r, col_nxt;

  logic signed [2*BW-1:0] m_sycp_r, m_cycp_r, m_sysp_r, m_cysp_r;
  logic signed [BW-1:0]   cy1_r, sy1_r, sp1_r, cp1_r, sr1_r, cr1_r, sr2_r, cr2_r;
  logic signed [BW-1:0]   fwd2_r [3], rgt2_r [3], upv2_r [3];
  logic signed [BW-1:0]   fwd3_r [3], rgt3_r [3], upv3_r [3];
  logic signed [2*BW-1:0] p_rc_r [3], p_us_r [3], p_uc_r [3], p_rs_r [3];
  logic signed [RW-1:0]   rr4_r [3], ru4_r [3], ff4_r [3];
  logic signed [DPW-1:0]  d_r_r [3], d_u_r [3], d_f_r [3];
  logic signed [39:0]     c0_5_r [3], c1_5_r [3], c2_5_r [3];
  logic signed [39:0]     col0_r [3], col1_r [3], col2_r [3], col3_r [3];
  logic [14:0]            fov_r;
  logic                   out_xfer;

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign adv   = !fin_v_r || (out_xfer && (col_r == COL_TRANS));
  assign q_pop = adv;

  ecv_cordic #(.ITER(ITER), .BFB(BFB)) u_yaw (
    .clk(clk), .en(adv), .angle(q_item.yaw), .sin_o(sy), .cos_o(cy));
  ecv_cordic #(.ITER(ITER), .BFB(BFB)) u_pitch (
    .clk(clk), .en(adv), .angle(q_item.pitch), .sin_o(sp), .cos_o(cp));
  ecv_cordic #(.ITER(ITER), .BFB(BFB)) u_roll (
    .clk(clk), .en(adv), .angle(q_item.roll), .sin_o(sr), .cos_o(cr));

  always_comb begin
    col_nxt = col_r;
    if (adv) col_nxt = COL_RIGHT;
    else if (out_xfer) col_nxt = col_r + 2'd1;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) sd_v_r[k] <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      fin_v_r <= 1'b0;
      col_r   <= COL_RIGHT;
    end else begin
      col_r <= col_nxt;
      if (adv) begin
        sd_v_r[0] <= q_valid;
        for (int k = 1; k < L; k++) sd_v_r[k] <= sd_v_r[k-1];
        v1_r    <= sd_v_r[L-1];
        v2_r    <= v1_r;
        v3_r    <= v2_r;
        v4_r    <= v3_r;
        v5_r    <= v4_r;
        fin_v_r <= v5_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= '{px: q_item.px, py: q_item.py, pz: q_item.pz, fov: q_item.fov,
                   rnz: (q_item.roll != 16'h0000)};
      for (int k = 1; k < L; k++) sd_r[k] <= sd_r[k-1];

      m_sycp_r <= sy * cp;
      m_cycp_r <= cy * cp;
      m_sysp_r <= sy * sp;
      m_cysp_r <= cy * sp;
      cy1_r <= cy;
      sy1_r <= sy;
      sp1_r <= sp;
      cp1_r <= cp;
      sr1_r <= sr;
      cr1_r <= cr;
      s1_r  <= sd_r[L-1];

      fwd2_r[0] <= BW'(-rnd2(ext2(m_sycp_r)));
      fwd2_r[1] <= -sp1_r;
      fwd2_r[2] <= BW'(rnd2(ext2(m_cycp_r)));
      rgt2_r[0] <= cy1_r;
      rgt2_r[1] <= '0;
      rgt2_r[2] <= sy1_r;
      upv2_r[0] <= BW'(-rnd2(ext2(m_sysp_r)));
      upv2_r[1] <= cp1_r;
      upv2_r[2] <= BW'(rnd2(ext2(m_cysp_r)));
      sr2_r <= sr1_r;
      cr2_r <= cr1_r;
      s2_r  <= s1_r;

      for (int j = 0; j < 3; j++) begin
        p_rc_r[j] <= rgt2_r[j] * cr2_r;
        p_us_r[j] <= upv2_r[j] * sr2_r;
        p_uc_r[j] <= upv2_r[j] * cr2_r;
        p_rs_r[j] <= rgt2_r[j] * sr2_r;
        fwd3_r[j] <= fwd2_r[j];
        rgt3_r[j] <= rgt2_r[j];
        upv3_r[j] <= upv2_r[j];
      end
      s3_r <= s2_r;

      for (int j = 0; j < 3; j++) begin
        if (s3_r.rnz) begin
          rr4_r[j] <= rnd2(ext2(p_rc_r[j]) + ext2(p_us_r[j]));
          ru4_r[j] <= rnd2(ext2(p_uc_r[j]) - ext2(p_rs_r[j]));
        end else begin
          rr4_r[j] <= RW'(rgt3_r[j]);
          ru4_r[j] <= RW'(upv3_r[j]);
        end
        ff4_r[j] <= RW'(fwd3_r[j]);
      end
      s4_r <= s3_r;

      d_r_r[0] <= rr4_r[0] * s4_r.px;
      d_r_r[1] <= rr4_r[1] * s4_r.py;
      d_r_r[2] <= rr4_r[2] * s4_r.pz;
      d_u_r[0] <= ru4_r[0] * s4_r.px;
      d_u_r[1] <= ru4_r[1] * s4_r.py;
      d_u_r[2] <= ru4_r[2] * s4_r.pz;
      d_f_r[0] <= ff4_r[0] * s4_r.px;
      d_f_r[1] <= ff4_r[1] * s4_r.py;
      d_f_r[2] <= ff4_r[2] * s4_r.pz;
      for (int j = 0; j < 3; j++) begin
        c0_5_r[j] <= q16(rr4_r[j]);
        c1_5_r[j] <= q16(ru4_r[j]);
        c2_5_r[j] <= q16(ff4_r[j]);
      end
      s5_r <= s4_r;

      for (int j = 0; j < 3; j++) begin
        col0_r[j] <= c0_5_r[j];
        col1_r[j] <= c1_5_r[j];
        col2_r[j] <= c2_5_r[j];
      end
      col3_r[0] <= ndot(d_r_r[0], d_r_r[1], d_r_r[2]);
      col3_r[1] <= ndot(d_u_r[0], d_u_r[1], d_u_r[2]);
      col3_r[2] <= ndot(d_f_r[0], d_f_r[1], d_f_r[2]);
      fov_r <= s5_r.fov;
    end
  end

  // column serializer
  always_comb begin
    out_ch.valid        = fin_v_r;
    out_ch.column_index = col_r;
    out_ch.fov_clamped  = fov_r;
    out_ch.elem_w       = '0;
    out_ch.last_column  = 1'b0;
    unique case (col_r)
      COL_RIGHT: begin
        out_ch.elem_x = col0_r[0];
        out_ch.elem_y = col0_r[1];
        out_ch.elem_z = col0_r[2];
      end
      COL_UP: begin
        out_ch.elem_x = col1_r[0];
        out_ch.elem_y = col1_r[1];
        out_ch.elem_z = col1_r[2];
      end
      COL_FWD: begin
        out_ch.elem_x = col2_r[0];
        out_ch.elem_y = col2_r[1];
        out_ch.elem_z = col2_r[2];
      end
      default: begin
        out_ch.elem_x      = col3_r[0];
        out_ch.elem_y      = col3_r[1];
        out_ch.elem_z      = col3_r[2];
        out_ch.elem_w      = W_ONE;
        out_ch.last_column = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_new_pose_starts_right: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_v_r) |-> (col_r == COL_RIGHT))
    else $error("new pose did not start at the right column");
  a_drain_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_v_r && out_xfer && (col_r == COL_TRANS) && !v5_r) |=> !fin_v_r)
    else $error("result stage kept valid after last transfer");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_v_r && !out_ch.ready) |=> (fin_v_r && $stable(col_r) && $stable(col3_r[0])))
    else $error("result changed while stalled");
  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_v_r && !(out_xfer && (col_r == COL_TRANS))) |=> ($stable(v5_r) && $stable(v1_r)))
    else $error("pipeline moved while results pending");
`endif

endmodule
